/* rtl/ffja_pkg.sv */
// Shared types, widths and constants for the first-fit job allocator.
package ffja_pkg;

	localparam int unsigned ID_W    = 16;
	localparam int unsigned MEM_W   = 10;
	localparam int unsigned CPU_W   = 8;
	localparam int unsigned ACT_W   = 3;
	localparam int unsigned IDX_W   = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 10;

	localparam int unsigned NODES_DEF = 4;

	localparam logic [MEM_W-1:0] MEM_CAP_RST = MEM_W'(64);
	localparam logic [CPU_W-1:0] CPU_CAP_RST = CPU_W'(24);
	localparam logic [ACT_W-1:0] ACTIVE_RST  = ACT_W'(2);

	localparam logic [CFG_IDX_W-1:0] REG_MEM_CAP = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CPU_CAP = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE  = CFG_IDX_W'(2);

	typedef struct packed {
		logic [ID_W-1:0]  job_id;
		logic [MEM_W-1:0] mem_need;
		logic [CPU_W-1:0] cpu_need;
	} job_t;

	typedef struct packed {
		logic [ID_W-1:0]  job_tag;
		logic             placed;
		logic [IDX_W-1:0] node_index;
	} res_t;

	typedef struct packed {
		job_t             job;
		logic             placed;
		logic [IDX_W-1:0] node_index;
	} cell_word_t;

endpackage

/* rtl/ffja_cell.sv */
// One worker node: holds its free counts and places a passing job if it fits.
module ffja_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic                          reload,
	input  logic [ffja_pkg::MEM_W-1:0]    cap_mem,
	input  logic [ffja_pkg::CPU_W-1:0]    cap_cpu,
	input  logic                          active,
	input  logic                          in_valid,
	input  ffja_pkg::cell_word_t          in_word,
	output logic                          out_valid,
	output ffja_pkg::cell_word_t          out_word
);

	localparam logic [ffja_pkg::IDX_W-1:0] CELL_TAG = ffja_pkg::IDX_W'(IDX);

	logic [ffja_pkg::MEM_W-1:0] free_mem_q;
	logic [ffja_pkg::CPU_W-1:0] free_cpu_q;
	logic                       out_valid_q;
	ffja_pkg::cell_word_t       out_word_q;
	ffja_pkg::cell_word_t       next_word;
	logic                       fit;

	always_comb begin
		fit = in_valid && !in_word.placed && active
			&& (free_mem_q >= in_word.job.mem_need)
			&& (free_cpu_q >= in_word.job.cpu_need);
		next_word = in_word;
		if (fit) begin
			next_word.placed     = 1'b1;
			next_word.node_index = CELL_TAG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_mem_q  <= ffja_pkg::MEM_CAP_RST;
			free_cpu_q  <= ffja_pkg::CPU_CAP_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (reload) begin
				free_mem_q <= cap_mem;
				free_cpu_q <= cap_cpu;
			end else if (advance && fit) begin
				free_mem_q <= free_mem_q - in_word.job.mem_need;
				free_cpu_q <= free_cpu_q - in_word.job.cpu_need;
			end
			if (advance) begin
				out_valid_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q <= next_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

/* rtl/ffja_obuf.sv */
// Result register with a skid stage; holds the chain while a word waits.
module ffja_obuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  ffja_pkg::res_t       in_word,
	output logic                 full,
	output logic                 res_valid,
	input  logic                 res_stall,
	output ffja_pkg::res_t       res_data
);

	logic           out_valid_q;
	ffja_pkg::res_t out_word_q;
	logic           skid_full_q;
	ffja_pkg::res_t skid_word_q;
	logic           take;
	logic           push;

	assign take = out_valid_q && !res_stall;
	assign push = in_valid && !skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
			out_word_q  <= '0;
			skid_word_q <= '0;
		end else begin
			if (skid_full_q) begin
				if (take) begin
					out_word_q  <= skid_word_q;
					skid_full_q <= 1'b0;
				end
			end else if (push) begin
				if (!out_valid_q || take) begin
					out_word_q  <= in_word;
					out_valid_q <= 1'b1;
				end else begin
					skid_word_q <= in_word;
					skid_full_q <= 1'b1;
				end
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign full      = skid_full_q;
	assign res_valid = out_valid_q;
	assign res_data  = out_word_q;

endmodule

/* rtl/first_fit_job_allocator.sv */
// Top level: config registers, chain of node cells and result buffer.
//
//   channel | valid     | stall     | word
//   job     | job_valid | job_stall | job_data  (job_id, mem_need, cpu_need)
//   result  | res_valid | res_stall | res_data  (job_tag, placed, node_index)
//   config  | cfg_we    | -         | cfg_index, cfg_wdata
//
// One job accepted per cycle while job_stall is low; the first node cell loads it at the
// accepting edge, then each later cell and finally the result register, which offers it.
// After reset every node holds 64 memory units and 24 cores, two nodes active.
// A config write to index 0, 1 or 2 reloads all nodes at once with the capacities as written.
// job_stall rises only when the skid stage holds a word; the chain then holds.
module first_fit_job_allocator #(
	parameter int unsigned NODES = ffja_pkg::NODES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              job_valid,
	output logic                              job_stall,
	input  ffja_pkg::job_t                    job_data,
	output logic                              res_valid,
	input  logic                              res_stall,
	output ffja_pkg::res_t                    res_data,
	input  logic                              cfg_we,
	input  logic [ffja_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ffja_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	logic [ffja_pkg::MEM_W-1:0] mem_cap_q;
	logic [ffja_pkg::CPU_W-1:0] cpu_cap_q;
	logic [ffja_pkg::ACT_W-1:0] active_q;
	logic [ffja_pkg::MEM_W-1:0] mem_cap_nx;
	logic [ffja_pkg::CPU_W-1:0] cpu_cap_nx;
	logic                       reload;
	logic                       advance;
	logic                       obuf_full;
	logic [NODES-1:0]           act;
	logic                       valid_c [NODES+1];
	ffja_pkg::cell_word_t       word_c  [NODES+1];
	ffja_pkg::res_t             last_res;

	always_comb begin
		mem_cap_nx = mem_cap_q;
		cpu_cap_nx = cpu_cap_q;
		reload     = 1'b0;
		if (cfg_we) begin
			unique case (cfg_index)
				ffja_pkg::REG_MEM_CAP: begin
					mem_cap_nx = cfg_wdata[ffja_pkg::MEM_W-1:0];
					reload     = 1'b1;
				end
				ffja_pkg::REG_CPU_CAP: begin
					cpu_cap_nx = cfg_wdata[ffja_pkg::CPU_W-1:0];
					reload     = 1'b1;
				end
				ffja_pkg::REG_ACTIVE: begin
					reload = 1'b1;
				end
				default: begin
					reload = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_cap_q <= ffja_pkg::MEM_CAP_RST;
			cpu_cap_q <= ffja_pkg::CPU_CAP_RST;
			active_q  <= ffja_pkg::ACTIVE_RST;
		end else if (cfg_we) begin
			mem_cap_q <= mem_cap_nx;
			cpu_cap_q <= cpu_cap_nx;
			if (cfg_index == ffja_pkg::REG_ACTIVE) begin
				active_q <= cfg_wdata[ffja_pkg::ACT_W-1:0];
			end
		end
	end

	assign advance   = !obuf_full;
	assign job_stall = obuf_full;

	assign valid_c[0] = job_valid;
	assign word_c[0]  = '{job: job_data, placed: 1'b0, node_index: '0};

	for (genvar g = 0; g < NODES; g++) begin : g_cell
		assign act[g] = (32'(active_q) > 32'(g));

		ffja_cell #(
			.IDX(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.reload   (reload),
			.cap_mem  (mem_cap_nx),
			.cap_cpu  (cpu_cap_nx),
			.active   (act[g]),
			.in_valid (valid_c[g]),
			.in_word  (word_c[g]),
			.out_valid(valid_c[g+1]),
			.out_word (word_c[g+1])
		);
	end

	assign last_res = '{
		job_tag:    word_c[NODES].job.job_id,
		placed:     word_c[NODES].placed,
		node_index: word_c[NODES].node_index
	};

	ffja_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_c[NODES]),
		.in_word  (last_res),
		.full     (obuf_full),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data)
	);

endmodule
